>>> rtl/tsfc_pkg.sv
// shared widths, register codes and types for the touch sample filter and calibration core
package tsfc_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int COEF_FRAC_BITS = 16;

   localparam int FIELD_W = 12;
   localparam int COEF_W  = 32;
   localparam int POINT_W = 16;
   localparam int PROD_W  = COEF_W + SAMPLE_BITS + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int QUO_W   = ACC_W - COEF_FRAC_BITS;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;

   localparam logic [2:0] REG_RAW_MODE      = 3'd0;
   localparam logic [2:0] REG_PRESS_THRESH  = 3'd1;
   localparam logic [2:0] REG_GAIN_X_FROM_X = 3'd2;
   localparam logic [2:0] REG_GAIN_X_FROM_Y = 3'd3;
   localparam logic [2:0] REG_OFFSET_X      = 3'd4;
   localparam logic [2:0] REG_GAIN_Y_FROM_X = 3'd5;
   localparam logic [2:0] REG_GAIN_Y_FROM_Y = 3'd6;
   localparam logic [2:0] REG_OFFSET_Y      = 3'd7;

   localparam logic [FIELD_W-1:0] THRESH_RESET = FIELD_W'(100);
   localparam logic [COEF_W-1:0]  UNITY_GAIN   = COEF_W'(1) << COEF_FRAC_BITS;

   typedef struct packed {
      logic                     raw_mode;
      logic [FIELD_W-1:0]       pressure_threshold;
      logic signed [COEF_W-1:0] gain_x_from_x;
      logic signed [COEF_W-1:0] gain_x_from_y;
      logic signed [COEF_W-1:0] offset_x;
      logic signed [COEF_W-1:0] gain_y_from_x;
      logic signed [COEF_W-1:0] gain_y_from_y;
      logic signed [COEF_W-1:0] offset_y;
   } cfg_type;

endpackage

>>> rtl/tsfc_regs.sv
// configuration register file behind the apb-style port
module tsfc_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tsfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tsfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output tsfc_pkg::cfg_type                   cfg
);

   tsfc_pkg::cfg_type cfg_ff;
   tsfc_pkg::cfg_type cfg_in;
   logic [2:0]        reg_sel;
   logic              wr_en;

   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            tsfc_pkg::REG_RAW_MODE:      cfg_in.raw_mode = csr_pwdata[0];
            tsfc_pkg::REG_PRESS_THRESH:
               cfg_in.pressure_threshold = csr_pwdata[tsfc_pkg::FIELD_W-1:0];
            tsfc_pkg::REG_GAIN_X_FROM_X: cfg_in.gain_x_from_x = csr_pwdata;
            tsfc_pkg::REG_GAIN_X_FROM_Y: cfg_in.gain_x_from_y = csr_pwdata;
            tsfc_pkg::REG_OFFSET_X:      cfg_in.offset_x = csr_pwdata;
            tsfc_pkg::REG_GAIN_Y_FROM_X: cfg_in.gain_y_from_x = csr_pwdata;
            tsfc_pkg::REG_GAIN_Y_FROM_Y: cfg_in.gain_y_from_y = csr_pwdata;
            tsfc_pkg::REG_OFFSET_Y:      cfg_in.offset_y = csr_pwdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tsfc_pkg::REG_RAW_MODE:
            csr_prdata = {{(tsfc_pkg::CSR_DATA_W-1){1'b0}}, cfg_ff.raw_mode};
         tsfc_pkg::REG_PRESS_THRESH:
            csr_prdata = {{(tsfc_pkg::CSR_DATA_W-tsfc_pkg::FIELD_W){1'b0}},
                          cfg_ff.pressure_threshold};
         tsfc_pkg::REG_GAIN_X_FROM_X: csr_prdata = cfg_ff.gain_x_from_x;
         tsfc_pkg::REG_GAIN_X_FROM_Y: csr_prdata = cfg_ff.gain_x_from_y;
         tsfc_pkg::REG_OFFSET_X:      csr_prdata = cfg_ff.offset_x;
         tsfc_pkg::REG_GAIN_Y_FROM_X: csr_prdata = cfg_ff.gain_y_from_x;
         tsfc_pkg::REG_GAIN_Y_FROM_Y: csr_prdata = cfg_ff.gain_y_from_y;
         tsfc_pkg::REG_OFFSET_Y:      csr_prdata = cfg_ff.offset_y;
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_mode           <= 1'b0;
         cfg_ff.pressure_threshold <= tsfc_pkg::THRESH_RESET;
         cfg_ff.gain_x_from_x      <= tsfc_pkg::UNITY_GAIN;
         cfg_ff.gain_x_from_y      <= '0;
         cfg_ff.offset_x           <= '0;
         cfg_ff.gain_y_from_x      <= '0;
         cfg_ff.gain_y_from_y      <= tsfc_pkg::UNITY_GAIN;
         cfg_ff.offset_y           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/tsfc_pair_avg.sv
// average of the two closest of three samples on one axis
module tsfc_pair_avg (
   input  logic [tsfc_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic [tsfc_pkg::SAMPLE_BITS-1:0] sample_b,
   input  logic [tsfc_pkg::SAMPLE_BITS-1:0] sample_c,
   output logic [tsfc_pkg::SAMPLE_BITS-1:0] average
);

   localparam int SW = tsfc_pkg::SAMPLE_BITS;

   logic [SW-1:0] d_ab;
   logic [SW-1:0] d_ac;
   logic [SW-1:0] d_bc;
   logic [SW:0]   pair_sum;

   assign d_ab = (sample_a > sample_b) ? sample_a - sample_b : sample_b - sample_a;
   assign d_ac = (sample_a > sample_c) ? sample_a - sample_c : sample_c - sample_a;
   assign d_bc = (sample_b > sample_c) ? sample_b - sample_c : sample_c - sample_b;

   // ties go to a/b first, then a/c
   always_comb begin
      if (d_ab <= d_ac && d_ab <= d_bc) begin
         pair_sum = {1'b0, sample_a} + {1'b0, sample_b};
      end else if (d_ac <= d_bc) begin
         pair_sum = {1'b0, sample_a} + {1'b0, sample_c};
      end else begin
         pair_sum = {1'b0, sample_b} + {1'b0, sample_c};
      end
   end

   assign average = pair_sum[SW:1];

endmodule

>>> rtl/tsfc_affine.sv
// one calibrated axis: product stage, sum stage plus a half, then truncate toward zero and saturate
module tsfc_affine (
   input  logic                                   clock,
   input  logic                                   mul_en,
   input  logic                                   sum_en,
   input  logic [tsfc_pkg::SAMPLE_BITS-1:0]       avg_x,
   input  logic [tsfc_pkg::SAMPLE_BITS-1:0]       avg_y,
   input  logic signed [tsfc_pkg::COEF_W-1:0]     gain_from_x,
   input  logic signed [tsfc_pkg::COEF_W-1:0]     gain_from_y,
   input  logic signed [tsfc_pkg::COEF_W-1:0]     offset,
   output logic signed [tsfc_pkg::POINT_W-1:0]    point
);

   localparam int PW = tsfc_pkg::PROD_W;
   localparam int AW = tsfc_pkg::ACC_W;
   localparam int QW = tsfc_pkg::QUO_W;
   localparam int FB = tsfc_pkg::COEF_FRAC_BITS;
   localparam int CW = tsfc_pkg::COEF_W;
   localparam logic signed [AW-1:0] HALF = AW'(1) << (FB - 1);
   localparam logic signed [QW-1:0] POS_MAX = QW'(32767);
   localparam logic signed [QW-1:0] NEG_MIN = -QW'(32768);

   logic signed [PW-1:0] prod_x_ff;
   logic signed [PW-1:0] prod_y_ff;
   logic signed [PW-1:0] prod_x_in;
   logic signed [PW-1:0] prod_y_in;
   logic signed [CW-1:0] offset_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] acc_in;
   logic signed [QW-1:0] quo;

   assign prod_x_in = gain_from_x * $signed({1'b0, avg_x});
   assign prod_y_in = gain_from_y * $signed({1'b0, avg_y});

   assign acc_in = {{(AW-PW){prod_x_ff[PW-1]}}, prod_x_ff}
                 + {{(AW-PW){prod_y_ff[PW-1]}}, prod_y_ff}
                 + {{(AW-CW){offset_ff[CW-1]}}, offset_ff}
                 + HALF;

   // arithmetic shift floors, so step up a negative value with a nonzero fraction
   assign quo = acc_ff[AW-1:FB]
              + QW'(acc_ff[AW-1] && (acc_ff[FB-1:0] != '0));

   always_comb begin
      if (quo > POS_MAX) begin
         point = tsfc_pkg::POINT_W'(POS_MAX);
      end else if (quo < NEG_MIN) begin
         point = tsfc_pkg::POINT_W'(NEG_MIN);
      end else begin
         point = quo[tsfc_pkg::POINT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         offset_ff <= offset;
      end
      if (sum_en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> rtl/touch_sample_filter_calibrate_core.sv
// top level: input register, pair filter, two calibrated axes, held point and result register
// One touch poll enters per clock while rsp_tready is high, through a five-register pipeline
// (input, averages, products, sum, result); rsp_tvalid rises when a poll reaches the result
// register, and a steady stream runs at one poll per cycle. Each stage advances whenever it is
// empty or the next one moves, so a stalled result only holds back polls that have no free stage
// left. The held point is updated in the result stage in poll order; a released poll returns the
// last touched point with pressed low. Write configuration only while no poll is in flight.
module touch_sample_filter_calibrate_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pressure, x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c
   input  logic [tsfc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_x, point_y
   output logic [tsfc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // pressed
   output logic                                 rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tsfc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsfc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsfc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int FW = tsfc_pkg::FIELD_W;
   localparam int SW = tsfc_pkg::SAMPLE_BITS;
   localparam int PTW = tsfc_pkg::POINT_W;

   tsfc_pkg::cfg_type cfg;

   // stage valids
   logic in_vld_ff, avg_vld_ff, mul_vld_ff, sum_vld_ff, out_vld_ff;
   logic in_en, avg_en, mul_en, sum_en, out_en;

   logic [FW*7-1:0] in_data_ff;
   logic [SW-1:0]   avg_x_in, avg_y_in, avg_x_ff, avg_y_ff, avg_x2_ff, avg_y2_ff;
   logic [SW-1:0]   avg_x3_ff, avg_y3_ff;
   logic            touch_in, touch1_ff, touch2_ff, touch3_ff;
   logic signed [PTW-1:0] cal_x, cal_y, new_x, new_y;
   logic signed [PTW-1:0] held_x_ff, held_y_ff, held_x_in, held_y_in;
   logic            pressed_ff;

   assign out_en = !out_vld_ff || rsp_tready;
   assign sum_en = !sum_vld_ff || out_en;
   assign mul_en = !mul_vld_ff || sum_en;
   assign avg_en = !avg_vld_ff || mul_en;
   assign in_en  = !in_vld_ff || avg_en;
   assign req_tready = in_en;

   tsfc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign touch_in = in_data_ff[FW-1:0] >= cfg.pressure_threshold;

   tsfc_pair_avg u_avg_x (
      .sample_a (in_data_ff[FW*1 +: SW]),
      .sample_b (in_data_ff[FW*2 +: SW]),
      .sample_c (in_data_ff[FW*3 +: SW]),
      .average  (avg_x_in)
   );

   tsfc_pair_avg u_avg_y (
      .sample_a (in_data_ff[FW*4 +: SW]),
      .sample_b (in_data_ff[FW*5 +: SW]),
      .sample_c (in_data_ff[FW*6 +: SW]),
      .average  (avg_y_in)
   );

   tsfc_affine u_cal_x (
      .clock       (clock),
      .mul_en      (mul_en),
      .sum_en      (sum_en),
      .avg_x       (avg_x_ff),
      .avg_y       (avg_y_ff),
      .gain_from_x (cfg.gain_x_from_x),
      .gain_from_y (cfg.gain_x_from_y),
      .offset      (cfg.offset_x),
      .point       (cal_x)
   );

   tsfc_affine u_cal_y (
      .clock       (clock),
      .mul_en      (mul_en),
      .sum_en      (sum_en),
      .avg_x       (avg_x_ff),
      .avg_y       (avg_y_ff),
      .gain_from_x (cfg.gain_y_from_x),
      .gain_from_y (cfg.gain_y_from_y),
      .offset      (cfg.offset_y),
      .point       (cal_y)
   );

   // raw averages only exceed the 16-bit range with 16-bit samples
   always_comb begin
      if (cfg.raw_mode) begin
         new_x = ({1'b0, 16'(avg_x3_ff)} > 17'd32767 && SW > 15) ? 16'sd32767
                                                                 : PTW'(avg_x3_ff);
         new_y = ({1'b0, 16'(avg_y3_ff)} > 17'd32767 && SW > 15) ? 16'sd32767
                                                                 : PTW'(avg_y3_ff);
      end else begin
         new_x = cal_x;
         new_y = cal_y;
      end
   end

   assign held_x_in = (sum_vld_ff && touch3_ff) ? new_x : held_x_ff;
   assign held_y_in = (sum_vld_ff && touch3_ff) ? new_y : held_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         avg_vld_ff <= 1'b0;
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         held_x_ff  <= '0;
         held_y_ff  <= '0;
      end else begin
         if (in_en)  in_vld_ff  <= req_tvalid;
         if (avg_en) avg_vld_ff <= in_vld_ff;
         if (mul_en) mul_vld_ff <= avg_vld_ff;
         if (sum_en) sum_vld_ff <= mul_vld_ff;
         if (out_en) begin
            out_vld_ff <= sum_vld_ff;
            held_x_ff  <= held_x_in;
            held_y_ff  <= held_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_data_ff <= req_tdata[FW*7-1:0];
      end
      if (avg_en) begin
         avg_x_ff  <= avg_x_in;
         avg_y_ff  <= avg_y_in;
         touch1_ff <= touch_in;
      end
      if (mul_en) begin
         avg_x2_ff <= avg_x_ff;
         avg_y2_ff <= avg_y_ff;
         touch2_ff <= touch1_ff;
      end
      if (sum_en) begin
         avg_x3_ff <= avg_x2_ff;
         avg_y3_ff <= avg_y2_ff;
         touch3_ff <= touch2_ff;
      end
      if (out_en) begin
         pressed_ff <= touch3_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {held_y_ff, held_x_ff};
   assign rsp_tuser  = pressed_ff;

   // input is only refused when every stage holds a poll
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_vld_ff && avg_vld_ff && mul_vld_ff && sum_vld_ff && out_vld_ff))
      else $error("input refused with a free pipeline stage");

   a_held_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(held_x_ff) && $stable(held_y_ff)))
      else $error("held point moved while the result was stalled");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_vld_ff)
      else $error("accepted poll lost at the input register");

endmodule
